// ===== rtl/pqtba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue token bucket admission: shared package
// Beat formats, register indexes, status and request codes, reset values.
// ----------------------------------------------------------------------------
package pqtba_pkg;

  localparam int CREDIT_W = 24;
  localparam int SIZE_W   = 32;
  localparam int TICK_W   = 16;
  localparam int QIDX_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_CREDIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_PER_TICK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CREDITS      = 2'd2;

  // Register reset values
  localparam logic [CREDIT_W-1:0] RST_BYTES_PER_CREDIT = 24'd4096;
  localparam logic [CREDIT_W-1:0] RST_REFILL_PER_TICK  = 24'd64;
  localparam logic [CREDIT_W-1:0] RST_MAX_CREDITS      = 24'd1024;

  // Request types
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SUBMIT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [QIDX_W-1:0] queue_index;
    logic [TICK_W-1:0] tick_count;
    logic [SIZE_W-1:0] request_size;
  } pqtba_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CREDIT_W-1:0] credits_charged;
    logic [CREDIT_W-1:0] credits_left;
  } pqtba_out_t;

endpackage
`default_nettype wire

// ===== rtl/per_queue_token_bucket_admission.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue token bucket admission
// Keeps one credit count per queue. Tick beats refill a queue up to a cap;
// submit beats charge size / bytes-per-credit credits (at least one) and grant
// or hold the request.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  pqtba_in_t  (one item)
//   out_     output     out_valid/out_stall  pqtba_out_t (one result)
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A submit beat passes from acceptance to the result register through a setup
// step, the restoring divider (one quotient bit per cycle), a charge step and
// a hand-off step. A tick beat goes through setup with the 16x24 multiply,
// add and cap, and hand-off; a bad queue index goes from setup to hand-off.
// One item is in flight at a time and in_stall stays high until the result
// register loads. Reset is synchronous; credit counts read as the refill
// reset value until first written, so no clearing pass follows reset. A
// stalled result holds the block in its hand-off state until the output
// register drains.
// ----------------------------------------------------------------------------
module per_queue_token_bucket_admission
  import pqtba_pkg::*;
#(
  parameter int QUEUE_COUNT = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire pqtba_in_t            in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      pqtba_out_t           out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CREDIT_W-1:0]  cfg_wdata
);

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int DIV_STEPS = SIZE_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int PROD_W = TICK_W + CREDIT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_REFILL = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_CHARGE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  // Configuration registers
  logic [CREDIT_W-1:0] bpt_r, refill_r, max_r;

  // Sequencer and datapath registers
  logic [2:0]          state_r, state_nxt;
  pqtba_in_t           item_r, item_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SIZE_W-1:0]   div_q_r, div_q_nxt;
  logic [CREDIT_W-1:0] div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  pqtba_out_t          res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  pqtba_out_t          out_data_r, out_data_nxt;

  // Credit store
  logic [CREDIT_W-1:0] mem [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] vld_r;
  logic [CREDIT_W-1:0] rd_data_r;
  logic                rd_vld_r;
  logic                mem_we;
  logic [CREDIT_W-1:0] mem_wdata;
  logic [QW-1:0]       item_addr, in_addr;

  logic                accept;
  logic                bad_q;
  logic [CREDIT_W-1:0] credit;
  logic [CREDIT_W-1:0] bpt_eff;
  logic [PROD_W:0]     refill_sum;
  logic [CREDIT_W-1:0] refill_cap;
  logic [CREDIT_W:0]   div_shift;
  logic [CREDIT_W+1:0] div_diff;
  logic                div_ge;
  logic [SIZE_W-1:0]   need;
  logic                grant;
  logic [CREDIT_W-1:0] credit_after;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_addr   = QW'(in_data.queue_index);
  assign item_addr = QW'(item_r.queue_index);
  assign bad_q     = 9'(item_r.queue_index) >= 9'(QUEUE_COUNT);

  // An entry never written reads as the refill reset value.
  assign credit  = rd_vld_r ? rd_data_r : RST_REFILL_PER_TICK;
  assign bpt_eff = (bpt_r == '0) ? CREDIT_W'(1) : bpt_r;

  assign refill_sum = (PROD_W+1)'(credit) + (PROD_W+1)'(prod_r);
  assign refill_cap = (refill_sum > (PROD_W+1)'(max_r)) ? max_r
                                                       : refill_sum[CREDIT_W-1:0];

  // One restoring division step: shift in the next dividend bit and subtract.
  assign div_shift = {div_rem_r, div_q_r[SIZE_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, bpt_eff};
  assign div_ge    = !div_diff[CREDIT_W+1];

  assign need         = (div_q_r == '0) ? SIZE_W'(1) : div_q_r;
  assign grant        = need <= SIZE_W'(credit);
  assign credit_after = credit - need[CREDIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_r    <= RST_BYTES_PER_CREDIT;
      refill_r <= RST_REFILL_PER_TICK;
      max_r    <= RST_MAX_CREDITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTES_PER_CREDIT: bpt_r    <= cfg_wdata;
        REG_REFILL_PER_TICK:  refill_r <= cfg_wdata;
        REG_MAX_CREDITS:      max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    prod_nxt      = prod_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = credit;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (bad_q) begin
          res_nxt   = '{status: ST_BAD, credits_charged: '0, credits_left: '0};
          state_nxt = S_FINISH;
        end else if (item_r.req_type == REQ_TICK) begin
          prod_nxt  = PROD_W'(item_r.tick_count) * PROD_W'(refill_r);
          state_nxt = S_REFILL;
        end else begin
          div_q_nxt   = item_r.request_size;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_REFILL: begin
        mem_we    = 1'b1;
        mem_wdata = refill_cap;
        res_nxt   = '{status: ST_OK, credits_charged: '0, credits_left: refill_cap};
        state_nxt = S_FINISH;
      end
      S_DIV: begin
        div_rem_nxt = div_ge ? div_diff[CREDIT_W-1:0] : div_shift[CREDIT_W-1:0];
        div_q_nxt   = {div_q_r[SIZE_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CHARGE;
        end
      end
      S_CHARGE: begin
        if (grant) begin
          mem_we    = 1'b1;
          mem_wdata = credit_after;
          res_nxt   = '{status: ST_OK, credits_charged: need[CREDIT_W-1:0],
                        credits_left: credit_after};
        end else begin
          res_nxt = '{status: ST_HELD, credits_charged: '0, credits_left: credit};
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    prod_r     <= prod_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Credit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[item_addr] <= 1'b1;
      end
      if (accept) begin
        rd_vld_r <= vld_r[in_addr];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result appeared outside the hand-off state");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_REFILL || state_r == S_CHARGE) && !bad_q)
    else $error("credit store written outside refill or charge");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_BAD |->
      out_data_r.credits_charged == '0 && out_data_r.credits_left == '0)
    else $error("bad queue result carries credits");

  a_charge_only_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.credits_charged != '0 |-> out_data_r.status == ST_OK)
    else $error("credits charged on a result that was not granted");

  a_div_to_charge: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_cnt_r == CNT_W'(DIV_STEPS - 1) |=> state_r == S_CHARGE)
    else $error("divider did not hand over after its last step");
`endif

endmodule
`default_nettype wire
